FILE: design/e7_pkg.sv
// Shared types and constants for the E7 bank-switching cartridge mapper.
// Depends on nothing; used by e7_ctrl and e7_bank_switching_cartridge.
package e7_pkg;

  localparam int unsigned ROM_BYTES = 16384;
  localparam int unsigned RAM_BYTES = 1024;
  localparam int unsigned ROM_AW    = $clog2(ROM_BYTES);
  localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned BUS_AW    = 12;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_LOAD  = 2'd2;

  localparam logic [BUS_AW-1:0] HS_ROM_FIRST  = 12'hFE0;
  localparam logic [BUS_AW-1:0] HS_ROM_LAST   = 12'hFE6;
  localparam logic [BUS_AW-1:0] HS_RAM_MODE   = 12'hFE7;
  localparam logic [BUS_AW-1:0] HS_BANK_FIRST = 12'hFE8;
  localparam logic [BUS_AW-1:0] HS_BANK_LAST  = 12'hFEB;
  localparam logic [BUS_AW-1:0] LRAM_RD_START = 12'h400;
  localparam logic [BUS_AW-1:0] BRAM_WR_START = 12'h800;
  localparam logic [BUS_AW-1:0] BRAM_RD_START = 12'h900;
  localparam logic [BUS_AW-1:0] FIXED_START   = 12'hA00;
  localparam logic [ROM_AW-1:0] FIXED_BASE    = 14'h3A00;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_ROM,
    SRC_LRAM,
    SRC_BRAM
  } src_e;

  typedef struct packed {
    logic              rom_we;
    logic              rom_re;
    logic [ROM_AW-1:0] rom_addr;
    logic              lram_we;
    logic              lram_re;
    logic [RAM_AW-1:0] lram_addr;
    logic              bram_we;
    logic              bram_re;
    logic [RAM_AW-1:0] bram_addr;
    logic [DATA_W-1:0] wdata;
    src_e              src;
    logic              err;
  } mem_req_t;

endpackage

FILE: design/e7_mem.sv
// Single-port synchronous byte memory with registered, enable-held read data.
// Depends on nothing; instantiated for ROM, large RAM and banked RAM.
module e7_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/e7_ctrl.sv
// Address decode, hotspot bank registers and post-reset RAM clearing pass.
// Depends on e7_pkg; drives the memory requests of the top level.
module e7_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [1:0]                    action_i,
  input  logic [e7_pkg::BUS_AW-1:0]     bus_address_i,
  input  logic [e7_pkg::ROM_AW-1:0]     load_address_i,
  input  logic [e7_pkg::DATA_W-1:0]     data_in_i,
  output logic                          busy_o,
  output e7_pkg::mem_req_t              req_o
);

  logic [2:0]                rom_bank_q, rom_bank_d;
  logic                      ram_mode_q, ram_mode_d;
  logic [1:0]                ram_bank_q, ram_bank_d;
  logic                      busy_q, busy_d;
  logic [e7_pkg::RAM_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic                      hs_rom, hs_mode, hs_bank;
  e7_pkg::mem_req_t          req;

  assign hs_rom  = (bus_address_i >= e7_pkg::HS_ROM_FIRST) &&
                   (bus_address_i <= e7_pkg::HS_ROM_LAST);
  assign hs_mode = (bus_address_i == e7_pkg::HS_RAM_MODE);
  assign hs_bank = (bus_address_i >= e7_pkg::HS_BANK_FIRST) &&
                   (bus_address_i <= e7_pkg::HS_BANK_LAST);

  always_comb begin
    rom_bank_d = rom_bank_q;
    ram_mode_d = ram_mode_q;
    ram_bank_d = ram_bank_q;
    busy_d     = busy_q;
    clr_cnt_d  = clr_cnt_q;
    req        = '0;
    req.src    = e7_pkg::SRC_NONE;
    req.wdata  = data_in_i;
    if (busy_q) begin
      req.lram_we   = 1'b1;
      req.bram_we   = 1'b1;
      req.lram_addr = clr_cnt_q;
      req.bram_addr = clr_cnt_q;
      req.wdata     = '0;
      clr_cnt_d     = clr_cnt_q + 1'b1;
      if (clr_cnt_q == e7_pkg::RAM_AW'(e7_pkg::RAM_BYTES - 1)) begin
        busy_d = 1'b0;
      end
    end else if (accept_i) begin
      unique case (action_i)
        e7_pkg::ACT_READ: begin
          if (hs_rom) begin
            rom_bank_d = bus_address_i[2:0];
            ram_mode_d = 1'b0;
          end
          if (hs_mode) begin
            ram_mode_d = 1'b1;
          end
          if (hs_bank) begin
            ram_bank_d = bus_address_i[1:0];
          end
          if (bus_address_i < e7_pkg::BRAM_WR_START) begin
            if (ram_mode_d) begin
              req.lram_re   = 1'b1;
              req.lram_addr = bus_address_i[e7_pkg::RAM_AW-1:0];
              req.src       = e7_pkg::SRC_LRAM;
            end else begin
              req.rom_re   = 1'b1;
              req.rom_addr = {rom_bank_d, bus_address_i[10:0]};
              req.src      = e7_pkg::SRC_ROM;
            end
          end else if (bus_address_i < e7_pkg::FIXED_START) begin
            req.bram_re   = 1'b1;
            req.bram_addr = {ram_bank_d, bus_address_i[7:0]};
            req.src       = e7_pkg::SRC_BRAM;
          end else begin
            req.rom_re   = 1'b1;
            req.rom_addr = e7_pkg::FIXED_BASE +
                           e7_pkg::ROM_AW'(bus_address_i - e7_pkg::FIXED_START);
            req.src      = e7_pkg::SRC_ROM;
          end
        end
        e7_pkg::ACT_WRITE: begin
          if ((bus_address_i < e7_pkg::LRAM_RD_START) && ram_mode_q) begin
            req.lram_we   = 1'b1;
            req.lram_addr = bus_address_i[e7_pkg::RAM_AW-1:0];
          end else if ((bus_address_i >= e7_pkg::BRAM_WR_START) &&
                       (bus_address_i < e7_pkg::BRAM_RD_START)) begin
            req.bram_we   = 1'b1;
            req.bram_addr = {ram_bank_q, bus_address_i[7:0]};
          end else if (hs_rom) begin
            rom_bank_d = bus_address_i[2:0];
            ram_mode_d = 1'b0;
          end else if (hs_mode) begin
            ram_mode_d = 1'b1;
          end else if (hs_bank) begin
            ram_bank_d = bus_address_i[1:0];
          end else begin
            req.err = 1'b1;
          end
        end
        e7_pkg::ACT_LOAD: begin
          req.rom_we   = 1'b1;
          req.rom_addr = load_address_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bank_q <= '0;
      ram_mode_q <= 1'b0;
      ram_bank_q <= '0;
      busy_q     <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      rom_bank_q <= rom_bank_d;
      ram_mode_q <= ram_mode_d;
      ram_bank_q <= ram_bank_d;
      busy_q     <= busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  assign busy_o = busy_q;
  assign req_o  = req;

endmodule

FILE: design/e7_bank_switching_cartridge.sv
// Top level of the E7 cartridge mapper: control, three memories, output stages.
// Depends on e7_pkg, e7_ctrl and e7_mem.
//
//   channel | signals                                     | direction
//   in      | in_valid_i in_ready_o action_i bus_address_i | to block
//           | load_address_i data_in_i                    |
//   out     | out_valid_o out_ready_i read_data_o         | from block
//           | rom_write_error_o                           |
//
// One item per clock unless clearing or stalled; the read stage feeds the output register.
// Each item makes at most one access to one single-port memory, whose read data is registered.
// After reset a clearing pass zeroes all 1024 bytes of both RAMs; in_ready_o stays low.
// A stalled output holds its register; the read stage holds behind it, then input stalls.
module e7_bank_switching_cartridge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [e7_pkg::BUS_AW-1:0]     bus_address_i,
  input  logic [e7_pkg::ROM_AW-1:0]     load_address_i,
  input  logic [e7_pkg::DATA_W-1:0]     data_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [e7_pkg::DATA_W-1:0]     read_data_o,
  output logic                          rom_write_error_o
);

  logic                      busy;
  logic                      in_accept;
  logic                      s1_ready, s1_adv;
  e7_pkg::mem_req_t          req;
  logic [e7_pkg::DATA_W-1:0] rom_rdata, lram_rdata, bram_rdata, sel_rdata;

  logic                      s1_valid_q;
  e7_pkg::src_e              s1_src_q;
  logic                      s1_err_q;
  logic                      out_valid_q;
  logic [e7_pkg::DATA_W-1:0] read_data_q;
  logic                      err_q;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s1_adv;
  assign in_ready_o = s1_ready && !busy;
  assign in_accept  = in_valid_i && in_ready_o;

  e7_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .action_i       (action_i),
    .bus_address_i  (bus_address_i),
    .load_address_i (load_address_i),
    .data_in_i      (data_in_i),
    .busy_o         (busy),
    .req_o          (req)
  );

  e7_mem #(
    .DEPTH (e7_pkg::ROM_BYTES),
    .WIDTH (e7_pkg::DATA_W)
  ) u_rom (
    .clk_i   (clk_i),
    .we_i    (req.rom_we),
    .re_i    (req.rom_re),
    .addr_i  (req.rom_addr),
    .wdata_i (req.wdata),
    .rdata_o (rom_rdata)
  );

  e7_mem #(
    .DEPTH (e7_pkg::RAM_BYTES),
    .WIDTH (e7_pkg::DATA_W)
  ) u_lram (
    .clk_i   (clk_i),
    .we_i    (req.lram_we),
    .re_i    (req.lram_re),
    .addr_i  (req.lram_addr),
    .wdata_i (req.wdata),
    .rdata_o (lram_rdata)
  );

  e7_mem #(
    .DEPTH (e7_pkg::RAM_BYTES),
    .WIDTH (e7_pkg::DATA_W)
  ) u_bram (
    .clk_i   (clk_i),
    .we_i    (req.bram_we),
    .re_i    (req.bram_re),
    .addr_i  (req.bram_addr),
    .wdata_i (req.wdata),
    .rdata_o (bram_rdata)
  );

  always_comb begin
    unique case (s1_src_q)
      e7_pkg::SRC_ROM:  sel_rdata = rom_rdata;
      e7_pkg::SRC_LRAM: sel_rdata = lram_rdata;
      e7_pkg::SRC_BRAM: sel_rdata = bram_rdata;
      default:          sel_rdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_accept;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_src_q <= req.src;
      s1_err_q <= req.err;
    end
    if (s1_adv && s1_valid_q) begin
      read_data_q <= sel_rdata;
      err_q       <= s1_err_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = read_data_q;
  assign rom_write_error_o = err_q;

`ifndef NO_ASSERTIONS
  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted transaction did not reach the read stage");

  a_s1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_src_q)))
    else $error("read stage dropped a stalled transaction");

  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o)
    else $error("input ready during clearing pass");

  a_one_access : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> $onehot0({req.rom_we, req.rom_re, req.lram_we, req.lram_re,
                        req.bram_we, req.bram_re}))
    else $error("more than one memory access in a cycle");

  a_err_no_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rom_write_error_o) |-> (read_data_o == '0))
    else $error("error result carries read data");
`endif

endmodule

FILE: verif/e7_bank_switching_cartridge_tb.sv
// Testbench for the E7 cartridge mapper: directed table, then random bus traffic.
// Results are checked in order against typed rows or a model of mapper state.
// Depends on e7_pkg and e7_bank_switching_cartridge.
module e7_bank_switching_cartridge_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [e7_pkg::DATA_W-1:0] read_data;
    logic                      rom_error;
  } cart_result_t;

  typedef struct packed {
    logic [1:0]                act;
    logic [e7_pkg::BUS_AW-1:0] addr;
    logic [e7_pkg::ROM_AW-1:0] load;
    logic [e7_pkg::DATA_W-1:0] data;
    logic                      typed;
    logic [e7_pkg::DATA_W-1:0] rd;
    logic                      err;
  } dir_row_t;

  localparam int DIR_ROWS_N = 26;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{e7_pkg::ACT_READ,  12'h800, 14'h0000, 8'h00, 1'b1, 8'h00, 1'b0},
    '{e7_pkg::ACT_WRITE, 12'h000, 14'h0000, 8'h11, 1'b1, 8'h00, 1'b1},
    '{e7_pkg::ACT_WRITE, 12'hFFF, 14'h0000, 8'h22, 1'b1, 8'h00, 1'b1},
    '{e7_pkg::ACT_LOAD,  12'h000, 14'h0000, 8'h00, 1'b1, 8'h00, 1'b0},
    '{e7_pkg::ACT_LOAD,  12'hFFF, 14'h3FFF, 8'hFF, 1'b1, 8'h00, 1'b0},
    '{e7_pkg::ACT_LOAD,  12'h000, 14'h3A00, 8'h5A, 1'b1, 8'h00, 1'b0},
    '{e7_pkg::ACT_LOAD,  12'h000, 14'h3000, 8'hA5, 1'b1, 8'h00, 1'b0},
    '{e7_pkg::ACT_READ,  12'hA00, 14'h0000, 8'h00, 1'b1, 8'h5A, 1'b0},
    '{e7_pkg::ACT_READ,  12'hFFF, 14'h0000, 8'h00, 1'b1, 8'hFF, 1'b0},
    '{e7_pkg::ACT_READ,  12'hFE6, 14'h0000, 8'h00, 1'b0, 8'h00, 1'b0},
    '{e7_pkg::ACT_READ,  12'h000, 14'h0000, 8'h00, 1'b0, 8'h00, 1'b0},
    '{e7_pkg::ACT_WRITE, 12'hFE7, 14'h0000, 8'h00, 1'b1, 8'h00, 1'b0},
    '{e7_pkg::ACT_WRITE, 12'h3FF, 14'h0000, 8'hFF, 1'b1, 8'h00, 1'b0},
    '{e7_pkg::ACT_READ,  12'h7FF, 14'h0000, 8'h00, 1'b1, 8'hFF, 1'b0},
    '{e7_pkg::ACT_READ,  12'h3FF, 14'h0000, 8'h00, 1'b1, 8'hFF, 1'b0},
    '{e7_pkg::ACT_WRITE, 12'h400, 14'h0000, 8'h44, 1'b1, 8'h00, 1'b1},
    '{e7_pkg::ACT_WRITE, 12'hFEB, 14'h0000, 8'h55, 1'b1, 8'h00, 1'b0},
    '{e7_pkg::ACT_WRITE, 12'h8FF, 14'h0000, 8'h81, 1'b1, 8'h00, 1'b0},
    '{e7_pkg::ACT_READ,  12'h9FF, 14'h0000, 8'h00, 1'b1, 8'h81, 1'b0},
    '{e7_pkg::ACT_READ,  12'h8FF, 14'h0000, 8'h00, 1'b1, 8'h81, 1'b0},
    '{e7_pkg::ACT_WRITE, 12'h9FF, 14'h0000, 8'h66, 1'b1, 8'h00, 1'b1},
    '{e7_pkg::ACT_READ,  12'hFE8, 14'h0000, 8'h00, 1'b0, 8'h00, 1'b0},
    '{e7_pkg::ACT_READ,  12'h9FF, 14'h0000, 8'h00, 1'b1, 8'h00, 1'b0},
    '{e7_pkg::ACT_WRITE, 12'hFE0, 14'h0000, 8'h00, 1'b1, 8'h00, 1'b0},
    '{ACT_NONE,          12'hFFF, 14'h3FFF, 8'hFF, 1'b1, 8'h00, 1'b0},
    '{e7_pkg::ACT_READ,  12'h000, 14'h0000, 8'h00, 1'b1, 8'h00, 1'b0}
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [1:0]                action_i = e7_pkg::ACT_READ;
  logic [e7_pkg::BUS_AW-1:0] bus_address_i = '0;
  logic [e7_pkg::ROM_AW-1:0] load_address_i = '0;
  logic [e7_pkg::DATA_W-1:0] data_in_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [e7_pkg::DATA_W-1:0] read_data_o;
  logic                      rom_write_error_o;

  e7_bank_switching_cartridge i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .bus_address_i    (bus_address_i),
    .load_address_i   (load_address_i),
    .data_in_i        (data_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .read_data_o      (read_data_o),
    .rom_write_error_o(rom_write_error_o)
  );

  logic [e7_pkg::DATA_W-1:0] rom_img [e7_pkg::ROM_BYTES];
  bit                        rom_loaded [e7_pkg::ROM_BYTES];
  logic [e7_pkg::DATA_W-1:0] large_ram [e7_pkg::RAM_BYTES];
  logic [e7_pkg::DATA_W-1:0] bank_ram [e7_pkg::RAM_BYTES];
  logic [2:0]                rom_bank_q;
  logic                      ram_mode_q;
  logic [1:0]                ram_bank_q;

  cart_result_t pending_results [$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  snd_idle_pct = 0;
  int unsigned  rcv_idle_pct = 0;
  int unsigned  stall_token = 0;
  int unsigned  stall_seen = 0;
  int unsigned  hold_left = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic bit switch_bank(input logic [e7_pkg::BUS_AW-1:0] a);
    if (a >= e7_pkg::HS_ROM_FIRST && a <= e7_pkg::HS_ROM_LAST) begin
      rom_bank_q = 3'(a - e7_pkg::HS_ROM_FIRST);
      ram_mode_q = 1'b0;
      return 1'b1;
    end
    if (a == e7_pkg::HS_RAM_MODE) begin
      ram_mode_q = 1'b1;
      return 1'b1;
    end
    if (a >= e7_pkg::HS_BANK_FIRST && a <= e7_pkg::HS_BANK_LAST) begin
      ram_bank_q = 2'(a - e7_pkg::HS_BANK_FIRST);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Resolve where a read lands, with the hotspot applied to local copies only.
  function automatic void rom_slot(input logic [e7_pkg::BUS_AW-1:0] a,
                                   output bit hits_rom,
                                   output logic [e7_pkg::ROM_AW-1:0] idx);
    logic [2:0] bank;
    logic       mode;
    bank = rom_bank_q;
    mode = ram_mode_q;
    idx = '0;
    if (a >= e7_pkg::HS_ROM_FIRST && a <= e7_pkg::HS_ROM_LAST) begin
      bank = 3'(a - e7_pkg::HS_ROM_FIRST);
      mode = 1'b0;
    end else if (a == e7_pkg::HS_RAM_MODE) begin
      mode = 1'b1;
    end
    if (a < e7_pkg::BRAM_WR_START) begin
      hits_rom = !mode;
      idx = {bank, a[10:0]};
    end else if (a < e7_pkg::FIXED_START) begin
      hits_rom = 1'b0;
    end else begin
      hits_rom = 1'b1;
      idx = e7_pkg::FIXED_BASE + 14'(a - e7_pkg::FIXED_START);
    end
  endfunction

  function automatic cart_result_t cart_step(input logic [1:0] act,
                                             input logic [e7_pkg::BUS_AW-1:0] a,
                                             input logic [e7_pkg::ROM_AW-1:0] ld,
                                             input logic [e7_pkg::DATA_W-1:0] d);
    cart_result_t              r;
    bit                        hits_rom;
    logic [e7_pkg::ROM_AW-1:0] idx;
    r = '0;
    case (act)
      e7_pkg::ACT_READ: begin
        rom_slot(a, hits_rom, idx);
        void'(switch_bank(a));
        if (hits_rom) r.read_data = rom_img[idx];
        else if (a < e7_pkg::BRAM_WR_START) r.read_data = large_ram[a[9:0]];
        else r.read_data = bank_ram[{ram_bank_q, a[7:0]}];
      end
      e7_pkg::ACT_WRITE: begin
        if (a < e7_pkg::LRAM_RD_START && ram_mode_q) large_ram[a[9:0]] = d;
        else if (a >= e7_pkg::BRAM_WR_START && a < e7_pkg::BRAM_RD_START)
          bank_ram[{ram_bank_q, a[7:0]}] = d;
        else r.rom_error = !switch_bank(a);
      end
      e7_pkg::ACT_LOAD: begin
        rom_img[ld] = d;
        rom_loaded[ld] = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic transfer(input logic [1:0] act, input logic [e7_pkg::BUS_AW-1:0] a,
                          input logic [e7_pkg::ROM_AW-1:0] ld,
                          input logic [e7_pkg::DATA_W-1:0] d,
                          input bit typed, input cart_result_t typed_r);
    cart_result_t pred;
    pred = cart_step(act, a, ld, d);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    bus_address_i  <= a;
    load_address_i <= ld;
    data_in_i      <= d;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(typed ? typed_r : pred);
  endtask

  // Load any not yet loaded ROM byte a read would hit before issuing the read.
  task automatic bus_cycle(input logic [1:0] act, input logic [e7_pkg::BUS_AW-1:0] a,
                           input logic [e7_pkg::ROM_AW-1:0] ld,
                           input logic [e7_pkg::DATA_W-1:0] d,
                           input bit typed, input cart_result_t typed_r);
    bit                        hits_rom;
    logic [e7_pkg::ROM_AW-1:0] idx;
    if (act == e7_pkg::ACT_READ) begin
      rom_slot(a, hits_rom, idx);
      if (hits_rom && !rom_loaded[idx])
        transfer(e7_pkg::ACT_LOAD, 12'($urandom), idx, 8'($urandom), 1'b0, '0);
    end
    transfer(act, a, ld, d, typed, typed_r);
  endtask

  task automatic random_transaction();
    logic [1:0]                act;
    logic [e7_pkg::BUS_AW-1:0] a;
    int unsigned               pick;
    pick = $urandom_range(99);
    a = 12'($urandom);
    case ($urandom_range(3))
      0: a[11:10] = 2'b00;
      1: a[11:10] = 2'b01;
      2: a[11:9] = 3'b100;
      default: ;
    endcase
    if (pick < 14) begin
      act = e7_pkg::ACT_LOAD;
    end else if (pick < 30) begin
      act = ($urandom_range(1) == 0) ? e7_pkg::ACT_READ : e7_pkg::ACT_WRITE;
      a = e7_pkg::HS_ROM_FIRST + 12'($urandom_range(11));
    end else if (pick < 62) begin
      act = e7_pkg::ACT_READ;
    end else if (pick < 97) begin
      act = e7_pkg::ACT_WRITE;
    end else begin
      act = ACT_NONE;
    end
    bus_cycle(act, a, 14'($urandom), 8'($urandom), 1'b0, '0);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cart_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", int'(read_data_o), 0);
      end else begin
        want = pending_results.pop_front();
        if (read_data_o !== want.read_data)
          report_mismatch("read_data", int'(read_data_o), int'(want.read_data));
        if (rom_write_error_o !== want.rom_error)
          report_mismatch("rom_write_error", int'(rom_write_error_o),
                          int'(want.rom_error));
      end
    end
    if (stall_token != stall_seen) begin
      stall_seen = stall_token;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[e7_bank_switching_cartridge] ERROR");
      $finish;
    end
  end

  initial begin
    foreach (large_ram[i]) large_ram[i] = '0;
    foreach (bank_ram[i]) bank_ram[i] = '0;
    rom_bank_q = '0;
    ram_mode_q = 1'b0;
    ram_bank_q = '0;
    snd_idle_pct = 36;
    rcv_idle_pct = 69;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS_N; i++) begin
      bus_cycle(DIR_ROWS[i].act, DIR_ROWS[i].addr, DIR_ROWS[i].load, DIR_ROWS[i].data,
                DIR_ROWS[i].typed, {DIR_ROWS[i].rd, DIR_ROWS[i].err});
    end
    repeat (140) random_transaction();
    drain_results();

    snd_idle_pct = 69;
    rcv_idle_pct = 36;
    repeat (140) random_transaction();
    drain_results();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    repeat (70) random_transaction();
    stall_token++;
    repeat (70) random_transaction();
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[e7_bank_switching_cartridge] OK");
    end else begin
      $display("[e7_bank_switching_cartridge] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/e7_pkg.sv
design/e7_mem.sv
design/e7_ctrl.sv
design/e7_bank_switching_cartridge.sv
verif/e7_bank_switching_cartridge_tb.sv
